@@ rtl/tpc_pkg.sv @@
// Shared widths, register codes and bundle types of the trapezoid profile calculator.
`default_nettype none

package tpc_pkg;

  localparam int RATE_W   = 24;
  localparam int FACTOR_W = 17;
  localparam int COUNT_W  = 32;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 32;
  localparam int EDGE_W   = 25;
  localparam int NSQ_W    = 48;
  localparam int ESQ_W    = 50;
  localparam int ACNT_W   = 56;
  localparam int RAD_W    = 58;
  localparam int ROOT_W   = 29;
  localparam int RATE_BITS_DEFAULT = 24;

  localparam logic [TIME_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [RATE_W-1:0] MIN_RATE_RESET   = 24'd120;
  localparam logic [CFG_W-1:0]  TIMER_RATE_RESET = 32'd2000000;

  typedef enum logic [1:0] {
    REG_MINIMAL_RATE = 2'd0,
    REG_TIMER_RATE   = 2'd1,
    REG_S_CURVE      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] accel_until;
    logic [COUNT_W-1:0] decel_after;
    logic [RATE_W-1:0]  start_rate;
    logic [RATE_W-1:0]  end_rate;
    logic [RATE_W-1:0]  peak_rate;
    logic [TIME_W-1:0]  accel_time;
    logic [TIME_W-1:0]  decel_time;
    logic [TIME_W-1:0]  accel_time_inv;
    logic [TIME_W-1:0]  decel_time_inv;
  } result_t;

  typedef struct packed {
    logic               acc_big;
    logic               dec_big;
    logic               x_big;
    logic               x_pos;
    logic               a_nz;
    logic [COUNT_W-1:0] cnt;
  } acc_side_t;

  typedef struct packed {
    logic [ESQ_W-1:0]  s2;
    logic [RATE_W-1:0] acc;
  } dec_side_t;

  typedef struct packed {
    logic [RATE_W-1:0] nom;
    logic [EDGE_W-1:0] s;
    logic [EDGE_W-1:0] e;
  } x_side_t;

  typedef struct packed {
    logic [COUNT_W-1:0] acc_until;
    logic [COUNT_W-1:0] dec_after;
    logic               plateau;
    logic [RATE_W-1:0]  nom;
    logic [EDGE_W-1:0]  s;
    logic [EDGE_W-1:0]  e;
    logic [RATE_W-1:0]  acc;
  } sq_side_t;

  typedef struct packed {
    logic               sat_a;
    logic               sat_d;
    logic [COUNT_W-1:0] acc_until;
    logic [COUNT_W-1:0] dec_after;
  } ta_side_t;

  typedef struct packed {
    logic [EDGE_W-1:0] s;
    logic [EDGE_W-1:0] e;
    logic [RATE_W-1:0] peak;
  } td_side_t;

  typedef struct packed {
    logic [TIME_W-1:0]  ta;
    logic [TIME_W-1:0]  td;
    logic [COUNT_W-1:0] acc_until;
    logic [COUNT_W-1:0] dec_after;
  } ia_side_t;

endpackage

`default_nettype wire

@@ rtl/tpc_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module tpc_div #(
  parameter int NW = 49,
  parameter int DW = 25,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [SW-1:0] side_out
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  // The caller guarantees that the quotient fits in QW bits.
  logic [W-1:0]  rem [QW];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [SW-1:0] sd  [QW+1];
  logic          v   [QW+1];

  assign rem[0] = W'(dividend);
  assign dv[0]  = divisor;
  assign q[0]   = '0;
  assign sd[0]  = side_in;
  assign v[0]   = in_valid;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [W-1:0] shifted;
    logic         fits;

    assign shifted = W'(dv[i]) << K;
    assign fits    = rem[i] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    // Bit K of the partial quotient is still clear here, so an OR sets it.
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
        q[i+1]  <= q[i] | (QW'(fits) << K);
      end
    end

    if (i < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= fits ? rem[i] - shifted : rem[i];
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign quotient  = q[QW];
  assign side_out  = sd[QW];

endmodule

`default_nettype wire

@@ rtl/tpc_isqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
`default_nettype none

module tpc_isqrt #(
  parameter int RW = 29,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  localparam int W = 2 * RW + 1;

  logic [W-1:0]  rem [RW];
  logic [RW-1:0] rt  [RW+1];
  logic [SW-1:0] sd  [RW+1];
  logic          v   [RW+1];

  assign rem[0] = W'(radicand);
  assign rt[0]  = '0;
  assign sd[0]  = side_in;
  assign v[0]   = in_valid;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam int B = RW - 1 - i;
    logic [W-1:0] trial;
    logic         fits;

    // Growing the root by 2^B raises its square by root*2^(B+1) + 2^(2B).
    assign trial = (W'(rt[i]) << (B + 1)) + (W'(1) << (2 * B));
    assign fits  = rem[i] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        rt[i+1] <= rt[i] | (RW'(fits) << B);
      end
    end

    if (i < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= fits ? rem[i] - trial : rem[i];
        end
      end
    end
  end

  assign out_valid = v[RW];
  assign root      = rt[RW];
  assign side_out  = sd[RW];

endmodule

`default_nettype wire

@@ rtl/tpc_outbuf.sv @@
// Output register with a skid entry that decouples the pipeline from the receiver.
`default_nettype none

module tpc_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tpc_pkg::result_t in_data,
  output logic             hold,
  output logic             out_valid,
  output tpc_pkg::result_t out_data,
  input  logic             stall
);

  import tpc_pkg::*;

  logic    skid_valid;
  result_t skid;

  assign hold = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && stall) begin
      if (in_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && stall) begin
      if (in_valid && !skid_valid) begin
        skid <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/trapezoid_profile_calc.sv @@
// Top level of the trapezoid profile calculator: segment in, profile result out.
//
// One segment is offered on the seg channel (seg_valid, seg_stall) with its nominal
// rate, entry and exit factors, acceleration and step count. One result leaves on the
// res channel (res_valid, res_stall) with the acceleration and deceleration points,
// the edge rates and, with s-curve enabled, the peak rate, the ramp times and their
// inverses. A transfer takes place at a clock edge with valid high and stall low.
// The block is a pipeline: one segment can be taken in every cycle while seg_stall
// is low. The depth is set by the three chained 32-bit dividers (steps, ramp times,
// inverses) and the 29-bit square root, each retiring one bit per stage.
// When the receiver stalls, the output register holds its result and one more result
// lands in a skid entry; while that entry is full the whole pipeline freezes and
// seg_stall is high. Nothing is dropped or repeated. Synchronous reset empties the
// pipeline and loads minimal_rate 120, timer_rate 2000000 and s-curve off. Registers
// are written through cfg_write, cfg_index and cfg_data by the user, only while the
// pipeline is empty; the block does not enforce this. An unknown index is ignored.
`default_nettype none

module trapezoid_profile_calc #(
  parameter int RATE_BITS = tpc_pkg::RATE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seg_valid,
  output logic                         seg_stall,
  input  logic [tpc_pkg::RATE_W-1:0]   cruise_rate,
  input  logic [tpc_pkg::FACTOR_W-1:0] entry_scale,
  input  logic [tpc_pkg::FACTOR_W-1:0] exit_scale,
  input  logic [tpc_pkg::RATE_W-1:0]   accel_rate,
  input  logic [tpc_pkg::COUNT_W-1:0]  step_count,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [tpc_pkg::CFG_W-1:0]    cfg_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [tpc_pkg::COUNT_W-1:0]  accel_until,
  output logic [tpc_pkg::COUNT_W-1:0]  decel_after,
  output logic [tpc_pkg::RATE_W-1:0]   start_rate,
  output logic [tpc_pkg::RATE_W-1:0]   end_rate,
  output logic [tpc_pkg::RATE_W-1:0]   peak_rate,
  output logic [tpc_pkg::TIME_W-1:0]   accel_time,
  output logic [tpc_pkg::TIME_W-1:0]   decel_time,
  output logic [tpc_pkg::TIME_W-1:0]   accel_time_inv,
  output logic [tpc_pkg::TIME_W-1:0]   decel_time_inv
);

  import tpc_pkg::*;

  localparam logic [32:0] RATE_MAX = (33'd1 << RATE_BITS) - 33'd1;

  // Configuration registers.
  logic [RATE_W-1:0] minimal_rate;
  logic [CFG_W-1:0]  timer_rate;
  logic              s_curve_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimal_rate   <= MIN_RATE_RESET;
      timer_rate     <= TIMER_RATE_RESET;
      s_curve_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MINIMAL_RATE: minimal_rate   <= cfg_data[RATE_W-1:0];
        REG_TIMER_RATE:   timer_rate     <= cfg_data;
        REG_S_CURVE:      s_curve_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic hold;
  logic en;

  assign en        = !hold;
  assign seg_stall = hold;

  function automatic logic [EDGE_W-1:0] rate_clamp(input logic [40:0] prod,
                                                   input logic [RATE_W-1:0] minr);
    logic [40:0]       sum;
    logic [EDGE_W-1:0] r;
    sum = prod + 41'd65535;
    r   = sum[40:16];
    if (r < EDGE_W'(minr)) r = EDGE_W'(minr);
    if (33'(r) > RATE_MAX) r = RATE_MAX[EDGE_W-1:0];
    return r;
  endfunction

  // Stage A: edge rate products.
  logic              a_valid;
  logic [40:0]       a_prod_s, a_prod_e;
  logic [RATE_W-1:0] a_nom, a_acc;
  logic [COUNT_W-1:0] a_cnt;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= seg_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_s <= 41'(cruise_rate) * 41'(entry_scale);
      a_prod_e <= 41'(cruise_rate) * 41'(exit_scale);
      a_nom    <= cruise_rate;
      a_acc    <= accel_rate;
      a_cnt    <= step_count;
    end
  end

  // Stage B: rounding and clamping of the edge rates.
  logic               b_valid;
  logic [EDGE_W-1:0]  b_s, b_e;
  logic [RATE_W-1:0]  b_nom, b_acc;
  logic [COUNT_W-1:0] b_cnt;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s   <= rate_clamp(a_prod_s, minimal_rate);
      b_e   <= rate_clamp(a_prod_e, minimal_rate);
      b_nom <= a_nom;
      b_acc <= a_acc;
      b_cnt <= a_cnt;
    end
  end

  // Stage C: squares and the acceleration-count product.
  logic               c_valid;
  logic [NSQ_W-1:0]   c_n2;
  logic [ESQ_W-1:0]   c_s2, c_e2;
  logic [ACNT_W-1:0]  c_acnt;
  logic [EDGE_W-1:0]  c_s, c_e;
  logic [RATE_W-1:0]  c_nom, c_acc;
  logic [COUNT_W-1:0] c_cnt;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (en) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_n2   <= NSQ_W'(b_nom) * NSQ_W'(b_nom);
      c_s2   <= ESQ_W'(b_s) * ESQ_W'(b_s);
      c_e2   <= ESQ_W'(b_e) * ESQ_W'(b_e);
      c_acnt <= ACNT_W'(b_acc) * ACNT_W'(b_cnt);
      c_s    <= b_s;
      c_e    <= b_e;
      c_nom  <= b_nom;
      c_acc  <= b_acc;
      c_cnt  <= b_cnt;
    end
  end

  // Stage D1: ramp distances and the intersection numerator (two's complement).
  logic               d_valid;
  logic [NSQ_W-1:0]   d_an, d_dn;
  logic [58:0]        d_num;
  logic [ACNT_W-1:0]  d_acnt;
  logic [ESQ_W-1:0]   d_s2;
  logic [EDGE_W-1:0]  d_s, d_e;
  logic [RATE_W-1:0]  d_nom, d_acc;
  logic [COUNT_W-1:0] d_cnt;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (en) d_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_an   <= (ESQ_W'(c_n2) > c_s2) ? c_n2 - c_s2[NSQ_W-1:0] : '0;
      d_dn   <= (ESQ_W'(c_n2) > c_e2) ? c_n2 - c_e2[NSQ_W-1:0] : '0;
      d_num  <= {2'b00, c_acnt, 1'b0} - 59'(c_s2) + 59'(c_e2);
      d_acnt <= c_acnt;
      d_s2   <= c_s2;
      d_s    <= c_s;
      d_e    <= c_e;
      d_nom  <= c_nom;
      d_acc  <= c_acc;
      d_cnt  <= c_cnt;
    end
  end

  // Stage D2: range checks so that every quotient that is used fits in 32 bits.
  logic       d_a_nz;
  logic [56:0] d_two_acnt;

  assign d_a_nz     = d_acc != '0;
  assign d_two_acnt = {d_acnt, 1'b0};

  logic               e_valid;
  logic [48:0]        e_acc_dvd;
  logic [NSQ_W-1:0]   e_dec_dvd;
  logic [58:0]        e_x_dvd;
  logic [EDGE_W-1:0]  e_two_a;
  logic [EDGE_W:0]    e_four_a;
  acc_side_t          e_acc_side;
  dec_side_t          e_dec_side;
  x_side_t            e_x_side;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else if (en) e_valid <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_acc_dvd  <= 49'(d_an) + 49'({d_acc, 1'b0}) - 49'd1;
      e_dec_dvd  <= d_dn;
      e_x_dvd    <= d_num + 59'({d_acc, 2'b00}) - 59'd1;
      e_two_a    <= {d_acc, 1'b0};
      e_four_a   <= {d_acc, 2'b00};
      e_acc_side.acc_big <= d_a_nz && (57'(d_an) > d_two_acnt);
      e_acc_side.dec_big <= d_a_nz &&
                            (58'(d_dn) >= 58'(d_two_acnt) + 58'({d_acc, 1'b0}));
      e_acc_side.x_big   <= d_num > {1'b0, d_acnt, 2'b00};
      e_acc_side.x_pos   <= d_a_nz && !d_num[58] && (d_num != '0);
      e_acc_side.a_nz    <= d_a_nz;
      e_acc_side.cnt     <= d_cnt;
      e_dec_side.s2      <= d_s2;
      e_dec_side.acc     <= d_acc;
      e_x_side.nom       <= d_nom;
      e_x_side.s         <= d_s;
      e_x_side.e         <= d_e;
    end
  end

  // Step-count dividers, run side by side.
  logic               qa_valid, qd_valid, qx_valid;
  logic [COUNT_W-1:0] qa, qd, qx;
  acc_side_t          qa_side;
  dec_side_t          qd_side;
  x_side_t            qx_side;

  tpc_div #(.NW(49), .DW(EDGE_W), .QW(COUNT_W), .SW($bits(acc_side_t))) u_div_acc (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_valid),
    .dividend(e_acc_dvd), .divisor(e_two_a), .side_in(e_acc_side),
    .out_valid(qa_valid), .quotient(qa), .side_out(qa_side)
  );

  tpc_div #(.NW(NSQ_W), .DW(EDGE_W), .QW(COUNT_W), .SW($bits(dec_side_t))) u_div_dec (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_valid),
    .dividend(e_dec_dvd), .divisor(e_two_a), .side_in(e_dec_side),
    .out_valid(qd_valid), .quotient(qd), .side_out(qd_side)
  );

  tpc_div #(.NW(59), .DW(EDGE_W + 1), .QW(COUNT_W), .SW($bits(x_side_t))) u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_valid),
    .dividend(e_x_dvd), .divisor(e_four_a), .side_in(e_x_side),
    .out_valid(qx_valid), .quotient(qx), .side_out(qx_side)
  );

  // Stage F: plateau decision.
  logic [COUNT_W-1:0] f_acc_n, f_dec_n, f_x_n;
  logic               f_plateau_n;

  always_comb begin
    f_acc_n     = qa_side.a_nz ? qa : '0;
    f_dec_n     = qa_side.a_nz ? qd : '0;
    f_plateau_n = !(qa_side.acc_big || qa_side.dec_big) &&
                  (33'(f_acc_n) + 33'(f_dec_n) <= 33'(qa_side.cnt));
    if (!qa_side.x_pos) f_x_n = '0;
    else if (qa_side.x_big) f_x_n = qa_side.cnt;
    else f_x_n = qx;
  end

  logic               f_valid;
  logic [COUNT_W-1:0] f_until, f_after;
  logic               f_plateau;
  logic [ESQ_W-1:0]   f_s2;
  logic [RATE_W-1:0]  f_acc, f_nom;
  logic [EDGE_W-1:0]  f_s, f_e;

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= qa_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_until   <= f_plateau_n ? f_acc_n : f_x_n;
      f_after   <= f_plateau_n ? qa_side.cnt - f_dec_n : f_x_n;
      f_plateau <= f_plateau_n;
      f_s2      <= qd_side.s2;
      f_acc     <= qd_side.acc;
      f_nom     <= qx_side.nom;
      f_s       <= qx_side.s;
      f_e       <= qx_side.e;
    end
  end

  // Stage G: acceleration times distance.
  logic               g_valid;
  logic [ACNT_W-1:0]  g_prod;
  logic [ESQ_W-1:0]   g_s2;
  sq_side_t           g_side;

  always_ff @(posedge clk) begin
    if (rst) g_valid <= 1'b0;
    else if (en) g_valid <= f_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_prod           <= ACNT_W'(f_acc) * ACNT_W'(f_until);
      g_s2             <= f_s2;
      g_side.acc_until <= f_until;
      g_side.dec_after <= f_after;
      g_side.plateau   <= f_plateau;
      g_side.nom       <= f_nom;
      g_side.s         <= f_s;
      g_side.e         <= f_e;
      g_side.acc       <= f_acc;
    end
  end

  // Stage H: radicand of the reached peak rate.
  logic             h_valid;
  logic [RAD_W-1:0] h_rad;
  sq_side_t         h_side;

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else if (en) h_valid <= g_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_rad  <= RAD_W'(g_s2) + {1'b0, g_prod, 1'b0};
      h_side <= g_side;
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t          sq_side;

  tpc_isqrt #(.RW(ROOT_W), .SW($bits(sq_side_t))) u_isqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_valid),
    .radicand(h_rad), .side_in(h_side),
    .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
  );

  // Stage I: peak rate and rate differences. The cruise rate of a plateau is
  // saturated to the rate range just like a computed root.
  logic [ROOT_W-1:0] i_peak_n;

  always_comb begin
    if (sq_side.plateau) i_peak_n = ROOT_W'(sq_side.nom);
    else i_peak_n = sq_root;
    if (33'(i_peak_n) > RATE_MAX) i_peak_n = RATE_MAX[ROOT_W-1:0];
  end

  logic               i_valid;
  logic [ROOT_W-1:0]  i_diff_a, i_diff_d;
  logic [RATE_W-1:0]  i_peak, i_acc;
  logic [EDGE_W-1:0]  i_s, i_e;
  logic [COUNT_W-1:0] i_until, i_after;

  always_ff @(posedge clk) begin
    if (rst) i_valid <= 1'b0;
    else if (en) i_valid <= sq_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_diff_a <= (i_peak_n > ROOT_W'(sq_side.s)) ? i_peak_n - ROOT_W'(sq_side.s) : '0;
      i_diff_d <= (i_peak_n > ROOT_W'(sq_side.e)) ? i_peak_n - ROOT_W'(sq_side.e) : '0;
      i_peak   <= i_peak_n[RATE_W-1:0];
      i_acc    <= sq_side.acc;
      i_s      <= sq_side.s;
      i_e      <= sq_side.e;
      i_until  <= sq_side.acc_until;
      i_after  <= sq_side.dec_after;
    end
  end

  // Stage J: rate differences scaled to timer ticks.
  logic               j_valid;
  logic [60:0]        j_ta_prod, j_td_prod;
  logic [RATE_W-1:0]  j_peak, j_acc;
  logic [EDGE_W-1:0]  j_s, j_e;
  logic [COUNT_W-1:0] j_until, j_after;

  always_ff @(posedge clk) begin
    if (rst) j_valid <= 1'b0;
    else if (en) j_valid <= i_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_ta_prod <= 61'(i_diff_a) * 61'(timer_rate);
      j_td_prod <= 61'(i_diff_d) * 61'(timer_rate);
      j_peak    <= i_peak;
      j_acc     <= i_acc;
      j_s       <= i_s;
      j_e       <= i_e;
      j_until   <= i_until;
      j_after   <= i_after;
    end
  end

  // Stage K: saturation of the ramp times; a time that would not fit in 32 bits,
  // or a zero acceleration, becomes all ones.
  logic [60:0] j_limit;

  assign j_limit = 61'({j_acc, 32'h0});

  logic               k_valid;
  logic [60:0]        k_ta_dvd, k_td_dvd;
  logic [RATE_W-1:0]  k_acc;
  ta_side_t           k_ta_side;
  td_side_t           k_td_side;

  always_ff @(posedge clk) begin
    if (rst) k_valid <= 1'b0;
    else if (en) k_valid <= j_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_ta_dvd            <= j_ta_prod;
      k_td_dvd            <= j_td_prod;
      k_acc               <= j_acc;
      k_ta_side.sat_a     <= (j_acc == '0) || (j_ta_prod >= j_limit);
      k_ta_side.sat_d     <= (j_acc == '0) || (j_td_prod >= j_limit);
      k_ta_side.acc_until <= j_until;
      k_ta_side.dec_after <= j_after;
      k_td_side.s         <= j_s;
      k_td_side.e         <= j_e;
      k_td_side.peak      <= j_peak;
    end
  end

  logic              ta_valid, td_valid;
  logic [TIME_W-1:0] ta_q, td_q;
  ta_side_t          ta_side;
  td_side_t          td_side;

  tpc_div #(.NW(61), .DW(RATE_W), .QW(TIME_W), .SW($bits(ta_side_t))) u_div_ta (
    .clk(clk), .rst(rst), .en(en), .in_valid(k_valid),
    .dividend(k_ta_dvd), .divisor(k_acc), .side_in(k_ta_side),
    .out_valid(ta_valid), .quotient(ta_q), .side_out(ta_side)
  );

  tpc_div #(.NW(61), .DW(RATE_W), .QW(TIME_W), .SW($bits(td_side_t))) u_div_td (
    .clk(clk), .rst(rst), .en(en), .in_valid(k_valid),
    .dividend(k_td_dvd), .divisor(k_acc), .side_in(k_td_side),
    .out_valid(td_valid), .quotient(td_q), .side_out(td_side)
  );

  // Stage M: final ramp times.
  logic              m_valid;
  logic [TIME_W-1:0] m_ta, m_td;
  ia_side_t          m_ia_side;
  td_side_t          m_id_side;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (en) m_valid <= ta_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ta                <= ta_side.sat_a ? ALL_ONES : ta_q;
      m_td                <= ta_side.sat_d ? ALL_ONES : td_q;
      m_ia_side.ta        <= ta_side.sat_a ? ALL_ONES : ta_q;
      m_ia_side.td        <= ta_side.sat_d ? ALL_ONES : td_q;
      m_ia_side.acc_until <= ta_side.acc_until;
      m_ia_side.dec_after <= ta_side.dec_after;
      m_id_side           <= td_side;
    end
  end

  logic              ia_valid, id_valid;
  logic [TIME_W-1:0] ia_q, id_q;
  ia_side_t          ia_side;
  td_side_t          id_side;

  tpc_div #(.NW(TIME_W), .DW(TIME_W), .QW(TIME_W), .SW($bits(ia_side_t))) u_div_ia (
    .clk(clk), .rst(rst), .en(en), .in_valid(m_valid),
    .dividend(ALL_ONES), .divisor(m_ta), .side_in(m_ia_side),
    .out_valid(ia_valid), .quotient(ia_q), .side_out(ia_side)
  );

  tpc_div #(.NW(TIME_W), .DW(TIME_W), .QW(TIME_W), .SW($bits(td_side_t))) u_div_id (
    .clk(clk), .rst(rst), .en(en), .in_valid(m_valid),
    .dividend(ALL_ONES), .divisor(m_td), .side_in(m_id_side),
    .out_valid(id_valid), .quotient(id_q), .side_out(id_side)
  );

  // Result assembly; the s-curve fields read as zero while s-curve is off.
  result_t fin;

  always_comb begin
    fin.accel_until    = ia_side.acc_until;
    fin.decel_after    = ia_side.dec_after;
    fin.start_rate     = id_side.s[RATE_W-1:0];
    fin.end_rate       = id_side.e[RATE_W-1:0];
    fin.peak_rate      = id_side.peak;
    fin.accel_time     = ia_side.ta;
    fin.decel_time     = ia_side.td;
    fin.accel_time_inv = (ia_side.ta == '0) ? ALL_ONES : ia_q;
    fin.decel_time_inv = (ia_side.td == '0) ? ALL_ONES : id_q;
    if (!s_curve_enable) begin
      fin.peak_rate      = '0;
      fin.accel_time     = '0;
      fin.decel_time     = '0;
      fin.accel_time_inv = '0;
      fin.decel_time_inv = '0;
    end
  end

  result_t res;

  tpc_outbuf u_outbuf (
    .clk(clk), .rst(rst), .in_valid(ia_valid), .in_data(fin),
    .hold(hold), .out_valid(res_valid), .out_data(res), .stall(res_stall)
  );

  assign accel_until    = res.accel_until;
  assign decel_after    = res.decel_after;
  assign start_rate     = res.start_rate;
  assign end_rate       = res.end_rate;
  assign peak_rate      = res.peak_rate;
  assign accel_time     = res.accel_time;
  assign decel_time     = res.decel_time;
  assign accel_time_inv = res.accel_time_inv;
  assign decel_time_inv = res.decel_time_inv;

  // Parallel dividers must stay in lock step.
  a_step_divs_aligned: assert property (@(posedge clk) disable iff (rst)
    (qa_valid == qd_valid) && (qa_valid == qx_valid))
    else $error("step-count dividers out of step");

  a_late_divs_aligned: assert property (@(posedge clk) disable iff (rst)
    (ta_valid == td_valid) && (ia_valid == id_valid))
    else $error("time or inverse dividers out of step");

  // Deceleration never starts before acceleration ends.
  a_points_ordered: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (f_until <= f_after))
    else $error("acceleration end lies after deceleration start");

  // The skid entry only fills behind a stalled result.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    hold |-> res_valid)
    else $error("skid entry full without a pending result");

endmodule

`default_nettype wire

@@ sim/trapezoid_profile_calc_checker.sv @@
// Checker that predicts every profile result from the accepted segments and compares it.
`timescale 1ns / 100ps

module trapezoid_profile_calc_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seg_valid,
  input  logic                         seg_stall,
  input  logic [tpc_pkg::RATE_W-1:0]   cruise_rate,
  input  logic [tpc_pkg::FACTOR_W-1:0] entry_scale,
  input  logic [tpc_pkg::FACTOR_W-1:0] exit_scale,
  input  logic [tpc_pkg::RATE_W-1:0]   accel_rate,
  input  logic [tpc_pkg::COUNT_W-1:0]  step_count,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [tpc_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         res_valid,
  input  logic                         res_stall,
  input  tpc_pkg::result_t             result,
  output int                           fail_count,
  output int                           pending,
  output int                           result_count
);
  import tpc_pkg::*;

  localparam logic [63:0] RATE_CEIL = 64'hFF_FFFF;

  logic [63:0] min_rate_q;
  logic [63:0] tick_rate_q;
  logic        scurve_q;
  result_t     profile_q[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] scaled_rate(input logic [63:0] nom, input logic [63:0] f);
    logic [63:0] r;
    r = (nom * f + 64'd65535) >> 16;
    if (r < min_rate_q) r = min_rate_q;
    if (r > RATE_CEIL) r = RATE_CEIL;
    return r;
  endfunction

  function automatic logic [31:0] ramp_ticks(input logic [63:0] hi, input logic [63:0] lo,
                                             input logic [63:0] a);
    logic [63:0] d;
    logic [127:0] t;
    if (a == 0) return ALL_ONES;
    d = (hi > lo) ? hi - lo : 0;
    t = ({64'd0, d} * {64'd0, tick_rate_q}) / a;
    return (t > 128'hFFFF_FFFF) ? ALL_ONES : t[31:0];
  endfunction

  function automatic result_t plan_profile(input logic [63:0] nom, input logic [63:0] ef,
                                           input logic [63:0] xf, input logic [63:0] a,
                                           input logic [63:0] cnt);
    result_t r;
    logic [63:0] s, e, n2, s2, e2, acc, dec, until_s, after_s, peak;
    logic signed [127:0] num, den, x;
    logic plateau;
    s = scaled_rate(nom, ef);
    e = scaled_rate(nom, xf);
    n2 = nom * nom;
    s2 = s * s;
    e2 = e * e;
    acc = 0;
    dec = 0;
    peak = 0;
    plateau = 1'b1;
    if (a != 0) begin
      if (n2 > s2) acc = (n2 - s2 + 2 * a - 1) / (2 * a);
      if (n2 > e2) dec = (n2 - e2) / (2 * a);
    end
    if ({1'b0, acc} + {1'b0, dec} > {1'b0, cnt}) begin
      num = $signed({64'd0, 2 * a * cnt}) - $signed({64'd0, s2}) + $signed({64'd0, e2});
      den = $signed({64'd0, 4 * a});
      x = 0;
      plateau = 1'b0;
      if (num > 0 && den > 0) x = (num + den - 1) / den;
      if (x > $signed({64'd0, cnt})) x = $signed({64'd0, cnt});
      until_s = x[63:0];
      after_s = x[63:0];
    end else begin
      until_s = acc;
      after_s = cnt - dec;
    end
    r = '0;
    if (scurve_q) begin
      peak = plateau ? nom : int_sqrt(s2 + 2 * a * until_s);
      if (peak > RATE_CEIL) peak = RATE_CEIL;
      r.accel_time = ramp_ticks(peak, s, a);
      r.decel_time = ramp_ticks(peak, e, a);
      r.accel_time_inv = (r.accel_time != 0) ? ALL_ONES / r.accel_time : ALL_ONES;
      r.decel_time_inv = (r.decel_time != 0) ? ALL_ONES / r.decel_time : ALL_ONES;
    end
    r.accel_until = until_s[31:0];
    r.decel_after = after_s[31:0];
    r.start_rate = s[23:0];
    r.end_rate = e[23:0];
    r.peak_rate = peak[23:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      min_rate_q <= 64'(MIN_RATE_RESET);
      tick_rate_q <= 64'(TIMER_RATE_RESET);
      scurve_q <= 1'b0;
      fail_count <= 0;
      result_count <= 0;
      profile_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_MINIMAL_RATE: min_rate_q <= {40'd0, cfg_data[23:0]};
          REG_TIMER_RATE: tick_rate_q <= {32'd0, cfg_data};
          REG_S_CURVE: scurve_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (seg_valid && !seg_stall)
        profile_q.push_back(plan_profile(cruise_rate, entry_scale, exit_scale,
                                         accel_rate, step_count));
      if (res_valid && !res_stall) begin
        result_count <= result_count + 1;
        if (profile_q.size() == 0) begin
          if (fail_count < 10)
            $display("ERROR: result transfer with no segment outstanding: %p", result);
          fail_count <= fail_count + 1;
        end else if (profile_q[0] !== result) begin
          if (fail_count < 10)
            $display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
                     result_count, profile_q[0], result);
          fail_count <= fail_count + 1;
          void'(profile_q.pop_front());
        end else begin
          void'(profile_q.pop_front());
        end
      end
    end
  end

  assign pending = profile_q.size();
endmodule

@@ sim/trapezoid_profile_calc_tb.sv @@
// Testbench top: drives segments and register writes, and gives the verdict.
`timescale 1ns / 100ps

module trapezoid_profile_calc_tb;
  import tpc_pkg::*;

  localparam int LATENCY = 138;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  logic [RATE_W-1:0] cruise_rate = '0;
  logic [FACTOR_W-1:0] entry_scale = '0;
  logic [FACTOR_W-1:0] exit_scale = '0;
  logic [RATE_W-1:0] accel_rate = '0;
  logic [COUNT_W-1:0] step_count = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  result_t result;
  int fail_count, pending, result_count;
  bit stall_quiet = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  trapezoid_profile_calc uut (
    .clk(clk), .rst(rst), .seg_valid(seg_valid), .seg_stall(seg_stall),
    .cruise_rate(cruise_rate), .entry_scale(entry_scale), .exit_scale(exit_scale),
    .accel_rate(accel_rate), .step_count(step_count), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .res_valid(res_valid),
    .res_stall(res_stall), .accel_until(result.accel_until),
    .decel_after(result.decel_after), .start_rate(result.start_rate),
    .end_rate(result.end_rate), .peak_rate(result.peak_rate),
    .accel_time(result.accel_time), .decel_time(result.decel_time),
    .accel_time_inv(result.accel_time_inv), .decel_time_inv(result.decel_time_inv)
  );

  trapezoid_profile_calc_checker checker_i (
    .clk(clk), .rst(rst), .seg_valid(seg_valid), .seg_stall(seg_stall),
    .cruise_rate(cruise_rate), .entry_scale(entry_scale), .exit_scale(exit_scale),
    .accel_rate(accel_rate), .step_count(step_count), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .res_valid(res_valid),
    .res_stall(res_stall), .result(result), .fail_count(fail_count),
    .pending(pending), .result_count(result_count)
  );

  // The receiver holds stall for a random number of cycles, then releases it for one
  // transfer; in quiet phases it never stalls.
  always @(posedge clk) begin : stall_gen
    int wait_left;
    if (rst) begin
      res_stall <= 1'b0;
      wait_left = 0;
    end else if (stall_quiet) begin
      res_stall <= 1'b0;
    end else if (wait_left > 0) begin
      wait_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if (res_valid) wait_left = $urandom_range(0, 9);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_segment(input logic [23:0] nom, input logic [16:0] ef,
                              input logic [16:0] xf, input logic [23:0] a,
                              input logic [31:0] cnt, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_valid <= 1'b1;
    cruise_rate <= nom;
    entry_scale <= ef;
    exit_scale <= xf;
    accel_rate <= a;
    step_count <= cnt;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    seg_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_factor();
    case ($urandom_range(0, 4))
      0: return 17'd65536;
      1: return 17'd0;
      2: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [23:0] rand_rate();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 4095));
      default: return 24'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 255));
      default: return 32'($urandom_range(0, 200000));
    endcase
  endfunction

  task automatic random_phase(input int n);
    bit burst;
    for (int i = 0; i < n; i++) begin
      burst = ($urandom_range(0, 3) == 0);
      send_segment(rand_rate(), rand_factor(), rand_factor(), rand_rate(), rand_count(),
                   burst);
    end
    drain_and_settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed segments with reset settings, then again with s-curve on.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) write_reg(REG_S_CURVE, 32'd1);
      send_segment(24'd1000, 17'd0, 17'd0, 24'd0, 32'd500, 1'b0);
      send_segment(24'hFFFFFF, 17'd65536, 17'd65536, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0);
      send_segment(24'hFFFFFF, 17'h1FFFF, 17'h1FFFF, 24'd1, 32'd10, 1'b0);
      send_segment(24'd0, 17'd0, 17'd0, 24'd0, 32'd0, 1'b1);
      send_segment(24'd20000, 17'd0, 17'd0, 24'd100, 32'd10, 1'b0);
      send_segment(24'd20000, 17'd100000, 17'd0, 24'd5000, 32'd3000, 1'b1);
      send_segment(24'd5000, 17'd30000, 17'd60000, 24'd50000, 32'd100000, 1'b0);
      send_segment(24'hFFFFFF, 17'd0, 17'd0, 24'd1, 32'hFFFFFFFF, 1'b0);
      send_segment(24'd12345, 17'd65536, 17'd0, 24'hFFFFFF, 32'd1, 1'b1);
      send_segment(24'd100, 17'd1, 17'd1, 24'd3, 32'd7, 1'b0);
      drain_and_settle();
    end

    write_reg(REG_TIMER_RATE, 32'hFFFFFFFF);
    write_reg(REG_MINIMAL_RATE, 32'h00FFFFFF);
    random_phase(60);
    write_reg(REG_TIMER_RATE, 32'd1);
    write_reg(REG_MINIMAL_RATE, 32'd1);
    write_reg(cfg_reg_t'(2'd3), 32'd12345);
    random_phase(150);
    write_reg(REG_TIMER_RATE, 32'd1000000);
    write_reg(REG_MINIMAL_RATE, 32'd500);
    write_reg(REG_S_CURVE, 32'd0);
    stall_quiet = 1'b1;
    random_phase(150);
    stall_quiet = 1'b0;
    write_reg(REG_S_CURVE, 32'd1);
    random_phase(250);
    write_reg(REG_TIMER_RATE, 32'($urandom_range(1, 50000000)));
    write_reg(REG_MINIMAL_RATE, 32'($urandom_range(1, 20000)));
    random_phase(220);

    $display("Covered %0d profile results over directed extremes and five register settings,",
             result_count);
    $display("with s-curve on and off and random gaps and stalls on both channels.");
    if (fail_count == 0)
      $display("trapezoid_profile_calc regression: pass");
    else
      $display("trapezoid_profile_calc regression: fail");
    $finish;
  end

  initial begin
    #5000000;
    $display("trapezoid_profile_calc regression: fail");
    $finish;
  end
endmodule
